// ===== hw/rtl/blg_pkg.sv =====
`timescale 1ns / 1ps

package blg_pkg;

   // Field widths of the request and response words.
   localparam int TIME_W  = 63;
   localparam int MV_W    = 12;
   localparam int LEVEL_W = 8;
   localparam int HOLD_W  = 32;

   // Configuration port.
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 3;
   localparam int REG_IDX_W = 1;

   // Battery voltage is the pin voltage times three: 12285 mV at most.
   localparam int VOLT_W = MV_W + 2;
   localparam int PCT_W  = 7;

   // Charge curve, highest voltage first.
   localparam int TABLE_POINTS = 15;
   localparam int SEG_COUNT    = TABLE_POINTS - 1;
   localparam int SEG_IDX_W    = $clog2(SEG_COUNT);

   localparam logic [VOLT_W-1:0] PT_MV [TABLE_POINTS] = '{
      14'd4120, 14'd4080, 14'd4020, 14'd3960, 14'd3900,
      14'd3840, 14'd3780, 14'd3720, 14'd3660, 14'd3600,
      14'd3540, 14'd3480, 14'd3400, 14'd3300, 14'd3000
   };

   localparam logic [PCT_W-1:0] PT_PCT [TABLE_POINTS] = '{
      7'd100, 7'd92, 7'd82, 7'd70, 7'd58,
      7'd47,  7'd37, 7'd28, 7'd20, 7'd14,
      7'd9,   7'd6,  7'd3,  7'd1,  7'd0
   };

   // Interpolation divides by twice the segment span through a scaled reciprocal.
   // The offset inside a segment stays below 300 mV, the numerator below 2048.
   localparam int RECIP_SHIFT = 21;
   localparam int OFS_W       = 9;
   localparam int MULT_W      = 19;
   localparam int BIAS_W      = 21;
   localparam int PROD_W      = 28;

   localparam logic [HOLD_W-1:0]  HOLD_RESET = 32'd5000000;
   localparam logic [LEVEL_W-1:0] LEVEL_NONE = 8'hFF;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ENABLE = 1'b0,
      REG_HOLD   = 1'b1
   } blg_reg_type;

   typedef struct packed {
      logic              enable;
      logic [HOLD_W-1:0] hold_interval_us;
   } blg_cfg_type;

endpackage

// ===== hw/rtl/blg_req_if.sv =====
`timescale 1ns / 1ps

interface blg_req_if;
   logic                        valid;
   logic                        ready;
   logic [blg_pkg::TIME_W-1:0]  now_us;
   logic                        sample_valid;
   logic [blg_pkg::MV_W-1:0]    sample_mv;

   modport source (output valid, now_us, sample_valid, sample_mv, input ready);
   modport sink   (input valid, now_us, sample_valid, sample_mv, output ready);
endinterface

// ===== hw/rtl/blg_rsp_if.sv =====
`timescale 1ns / 1ps

interface blg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [blg_pkg::LEVEL_W-1:0] level_percent;

   modport source (output valid, level_percent, input ready);
   modport sink   (input valid, level_percent, output ready);
endinterface

// ===== hw/rtl/battery_level_gauge.sv =====
`timescale 1ns / 1ps
// A word accepted on the request channel passes through the input stage and the
// result register to the response channel, one word per cycle unless that channel
// stalls. The hold check, the curve lookup and the interpolation multiply all sit
// between the input stage and the result register.
// Reset: clears the sample history, sets the cached level to -1, enable to 0
// and the hold interval to 5000000 us; both channels come out empty.

module battery_level_gauge (
   input  logic                        clock,
   input  logic                        reset,
   blg_req_if.sink                     req_chan,
   blg_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [blg_pkg::ADDR_W-1:0]  paddr,
   input  logic [blg_pkg::DATA_W-1:0]  pwdata,
   output logic [blg_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   blg_pkg::blg_cfg_type cfg;

   // Input stage.
   logic                          s1_valid_ff, s1_valid_in;
   logic [blg_pkg::TIME_W-1:0]    s1_now_ff;
   logic                          s1_ok_ff;
   logic [blg_pkg::MV_W-1:0]      s1_mv_ff;

   // Sample history.
   logic                          has_sampled_ff, has_sampled_in;
   logic [blg_pkg::TIME_W-1:0]    last_sample_ff, last_sample_in;
   logic [blg_pkg::LEVEL_W-1:0]   cached_level_ff, cached_level_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [blg_pkg::LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   logic                          req_fire;
   logic                          rsp_fire;
   logic                          out_free;
   logic                          s1_fire;
   logic [blg_pkg::TIME_W:0]      elapsed;
   logic                          held;
   logic [blg_pkg::LEVEL_W-1:0]   conv_level;
   logic [blg_pkg::LEVEL_W-1:0]   level_out;

   blg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   blg_convert u_convert (
      .sample_mv (s1_mv_ff),
      .level     (conv_level)
   );

   // Handshakes: the input stage moves on whenever the result register is free.
   // No word is taken while reset is asserted.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && out_free;
   assign req_chan.ready = !reset && (!s1_valid_ff || out_free);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.level_percent = rsp_level_ff;

   // Hold check; a borrow means time went backwards, which also counts as held.
   assign elapsed = {1'b0, s1_now_ff} - {1'b0, last_sample_ff};
   assign held    = has_sampled_ff &&
                    (elapsed[blg_pkg::TIME_W] ||
                     (elapsed[blg_pkg::TIME_W-1:0] <
                      blg_pkg::TIME_W'(cfg.hold_interval_us)));

   // State update and result selection for the word in the input stage.
   always_comb begin
      has_sampled_in  = has_sampled_ff;
      last_sample_in  = last_sample_ff;
      cached_level_in = cached_level_ff;
      level_out       = cached_level_ff;
      if (s1_fire) begin
         if (!cfg.enable) begin
            level_out = blg_pkg::LEVEL_NONE;
         end else if (!held) begin
            has_sampled_in = 1'b1;
            last_sample_in = s1_now_ff;
            if (s1_ok_ff) begin
               cached_level_in = conv_level;
            end
            level_out = cached_level_in;
         end
      end
   end

   // Valid flags of both stages.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = level_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         has_sampled_ff  <= 1'b0;
         last_sample_ff  <= '0;
         cached_level_ff <= blg_pkg::LEVEL_NONE;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         has_sampled_ff  <= has_sampled_in;
         last_sample_ff  <= last_sample_in;
         cached_level_ff <= cached_level_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_now_ff <= req_chan.now_us;
         s1_ok_ff  <= req_chan.sample_valid;
         s1_mv_ff  <= req_chan.sample_mv;
      end
      rsp_level_ff <= rsp_level_in;
   end

   // A word leaving the input stage always lands in the result register.
   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("input stage word did not reach the result register");

   // While disabled every result is -1.
   a_disabled_none: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !cfg.enable) |=> (rsp_level_ff == blg_pkg::LEVEL_NONE))
      else $error("disabled gauge returned a level other than -1");

   // The cached level is -1 or a percent.
   a_cached_range: assert property (@(posedge clock) disable iff (reset)
      ($signed(cached_level_ff) >= -8'sd1) && ($signed(cached_level_ff) <= 8'sd100))
      else $error("cached level out of range");

   // Once a sample is taken the history never clears outside reset.
   a_sampled_sticks: assert property (@(posedge clock) disable iff (reset)
      has_sampled_ff |=> has_sampled_ff)
      else $error("sample history lost");

   // The history only moves when a word is processed.
   a_history_quiet: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> ($stable(last_sample_ff) && $stable(cached_level_ff)))
      else $error("history changed without a word");

endmodule

// ===== hw/rtl/blg_csr.sv =====
`timescale 1ns / 1ps

module blg_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [blg_pkg::ADDR_W-1:0]  paddr,
   input  logic [blg_pkg::DATA_W-1:0]  pwdata,
   output logic [blg_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output blg_pkg::blg_cfg_type        cfg
);

   blg_pkg::blg_cfg_type cfg_ff;
   blg_pkg::blg_cfg_type cfg_in;
   blg_pkg::blg_reg_type reg_sel;
   logic                 wr_en;

   // Registers sit on 4-byte boundaries.
   assign reg_sel = blg_pkg::blg_reg_type'(paddr[2 +: blg_pkg::REG_IDX_W]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            blg_pkg::REG_ENABLE: cfg_in.enable = pwdata[0];
            blg_pkg::REG_HOLD: cfg_in.hold_interval_us = pwdata[blg_pkg::HOLD_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      case (reg_sel)
         blg_pkg::REG_ENABLE: prdata = {{(blg_pkg::DATA_W-1){1'b0}}, cfg_ff.enable};
         blg_pkg::REG_HOLD: prdata = blg_pkg::DATA_W'(cfg_ff.hold_interval_us);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= 1'b0;
         cfg_ff.hold_interval_us <= blg_pkg::HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/blg_convert.sv =====
`timescale 1ns / 1ps

module blg_convert (
   input  logic [blg_pkg::MV_W-1:0]     sample_mv,
   output logic [blg_pkg::LEVEL_W-1:0]  level
);

   logic [blg_pkg::VOLT_W-1:0] volt;
   logic [blg_pkg::SEG_COUNT-1:0] hit;
   logic [blg_pkg::MULT_W-1:0] seg_mult [blg_pkg::SEG_COUNT];
   logic [blg_pkg::BIAS_W-1:0] seg_bias [blg_pkg::SEG_COUNT];
   logic [blg_pkg::MULT_W-1:0] sel_mult;
   logic [blg_pkg::BIAS_W-1:0] sel_bias;
   logic [blg_pkg::VOLT_W-1:0] sel_lo_mv;
   logic [blg_pkg::PCT_W-1:0]  sel_lo_pct;
   logic [blg_pkg::VOLT_W-1:0] ofs_full;
   logic [blg_pkg::OFS_W-1:0]  ofs;
   logic [blg_pkg::PROD_W-1:0] prod;
   logic [blg_pkg::PCT_W-1:0]  quot;
   logic [blg_pkg::PCT_W-1:0]  pct;
   logic                       at_top;
   logic                       at_bottom;

   // Battery voltage is three times the pin voltage.
   assign volt = {1'b0, sample_mv, 1'b0} + {2'b00, sample_mv};

   // Per-segment constants: the numerator (ofs * 2 * dpct + span) is divided by
   // 2 * span through a reciprocal scaled by 2^RECIP_SHIFT, folded into one
   // multiply and one add.
   for (genvar k = 0; k < blg_pkg::SEG_COUNT; k++) begin : g_seg
      localparam int unsigned SPAN  = blg_pkg::PT_MV[k] - blg_pkg::PT_MV[k+1];
      localparam int unsigned DPCT  = blg_pkg::PT_PCT[k] - blg_pkg::PT_PCT[k+1];
      localparam int unsigned DIV2  = 2 * SPAN;
      localparam int unsigned RECIP = ((1 << blg_pkg::RECIP_SHIFT) + DIV2 - 1) / DIV2;
      localparam int unsigned MULT  = 2 * DPCT * RECIP;
      localparam int unsigned BIAS  = SPAN * RECIP;

      assign seg_mult[k] = blg_pkg::MULT_W'(MULT);
      assign seg_bias[k] = blg_pkg::BIAS_W'(BIAS);
      assign hit[k] = (volt >= blg_pkg::PT_MV[k+1]) && (volt < blg_pkg::PT_MV[k]);
   end

   // The segments are disjoint, so an AND-OR mux picks the constants.
   always_comb begin
      sel_mult   = '0;
      sel_bias   = '0;
      sel_lo_mv  = '0;
      sel_lo_pct = '0;
      for (int k = 0; k < blg_pkg::SEG_COUNT; k++) begin
         if (hit[k]) begin
            sel_mult   = sel_mult | seg_mult[k];
            sel_bias   = sel_bias | seg_bias[k];
            sel_lo_mv  = sel_lo_mv | blg_pkg::PT_MV[k+1];
            sel_lo_pct = sel_lo_pct | blg_pkg::PT_PCT[k+1];
         end
      end
   end

   // Interpolation within the selected segment, rounded half up.
   assign ofs_full = volt - sel_lo_mv;
   assign ofs      = ofs_full[blg_pkg::OFS_W-1:0];
   assign prod     = blg_pkg::PROD_W'(ofs) * blg_pkg::PROD_W'(sel_mult)
                     + blg_pkg::PROD_W'(sel_bias);
   assign quot     = prod[blg_pkg::RECIP_SHIFT +: blg_pkg::PCT_W];

   // Clamp outside the curve.
   assign at_top    = volt >= blg_pkg::PT_MV[0];
   assign at_bottom = volt <= blg_pkg::PT_MV[blg_pkg::TABLE_POINTS-1];

   always_comb begin
      if (at_top) begin
         pct = blg_pkg::PT_PCT[0];
      end else if (at_bottom) begin
         pct = blg_pkg::PT_PCT[blg_pkg::TABLE_POINTS-1];
      end else begin
         pct = sel_lo_pct + quot;
      end
   end

   assign level = blg_pkg::LEVEL_W'(pct);

endmodule

// ===== test/battery_level_gauge_tb.sv =====
`timescale 1ns / 1ps

module battery_level_gauge_tb;

   localparam int WATCHDOG_LIMIT = 600;
   localparam int PRINT_LIMIT    = 40;
   localparam int CURVE_POINTS   = 15;
   localparam logic [blg_pkg::TIME_W-1:0] TIME_CEILING = {blg_pkg::TIME_W{1'b1}};

   // Charge curve of the cell, highest voltage first (battery mV, percent).
   localparam int unsigned CURVE_MV [CURVE_POINTS] = '{
      4120, 4080, 4020, 3960, 3900, 3840, 3780, 3720,
      3660, 3600, 3540, 3480, 3400, 3300, 3000
   };
   localparam int unsigned CURVE_PCT [CURVE_POINTS] = '{
      100, 92, 82, 70, 58, 47, 37, 28, 20, 14, 9, 6, 3, 1, 0
   };

   typedef struct packed {
      logic [blg_pkg::TIME_W-1:0] now_us;
      logic                       sample_valid;
      logic [blg_pkg::MV_W-1:0]   sample_mv;
   } gauge_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [blg_pkg::ADDR_W-1:0] paddr;
   logic [blg_pkg::DATA_W-1:0] pwdata;
   logic [blg_pkg::DATA_W-1:0] prdata;
   logic                       pready;

   blg_req_if req_bus ();
   blg_rsp_if rsp_bus ();

   // Mirror of the gauge state, at its reset values.
   logic                               gauge_enable = 1'b0;
   logic [blg_pkg::HOLD_W-1:0]         gauge_hold   = blg_pkg::HOLD_RESET;
   logic                               seen_sample  = 1'b0;
   logic [63:0]                        last_stamp   = 64'd0;
   logic signed [blg_pkg::LEVEL_W-1:0] held_level   = blg_pkg::LEVEL_NONE;

   logic signed [blg_pkg::LEVEL_W-1:0] level_expected [$];
   logic signed [blg_pkg::LEVEL_W-1:0] level_wanted;
   logic [blg_pkg::TIME_W-1:0]         stream_clock = '0;

   bit idle_on = 1'b1;
   int mismatches;
   int words_sent;
   int levels_checked;
   int fresh_reads;
   int quiet_cycles;

   battery_level_gauge u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
   endtask

   // Linear interpolation between curve points, rounded half up.
   function automatic logic signed [blg_pkg::LEVEL_W-1:0] percent_for_battery(
      input int unsigned batt_mv);
      longint unsigned span;
      longint unsigned num;
      if (batt_mv >= CURVE_MV[0]) return blg_pkg::LEVEL_W'(CURVE_PCT[0]);
      if (batt_mv <= CURVE_MV[CURVE_POINTS-1])
         return blg_pkg::LEVEL_W'(CURVE_PCT[CURVE_POINTS-1]);
      for (int k = 0; k < CURVE_POINTS - 1; k++) begin
         if (batt_mv >= CURVE_MV[k+1] && batt_mv < CURVE_MV[k]) begin
            span = longint'(CURVE_MV[k] - CURVE_MV[k+1]);
            num  = longint'(batt_mv - CURVE_MV[k+1]) *
                   longint'(CURVE_PCT[k] - CURVE_PCT[k+1]) * 2 + span;
            return blg_pkg::LEVEL_W'(longint'(CURVE_PCT[k+1]) + num / (2 * span));
         end
      end
      return blg_pkg::LEVEL_NONE;
   endfunction

   // Work out the level that one accepted word must produce.
   task automatic predict_level(input gauge_sample_type s);
      logic [63:0] stamp;
      stamp = {1'b0, s.now_us};
      if (!gauge_enable) begin
         level_expected = {level_expected, blg_pkg::LEVEL_NONE};
      end else begin
         // A sample from the past or inside the hold window returns the cached level.
         if (!seen_sample ||
             (stamp >= last_stamp && stamp - last_stamp >= {32'b0, gauge_hold})) begin
            seen_sample = 1'b1;
            last_stamp  = stamp;
            if (s.sample_valid) begin
               held_level = percent_for_battery(int'(s.sample_mv) * 3);
               fresh_reads++;
            end
         end
         level_expected = {level_expected, held_level};
      end
   endtask

   // Offer one word, sometimes after a random gap, and hold it until it is taken.
   task automatic send_sample(input logic [blg_pkg::TIME_W-1:0] t, input logic ok,
                              input logic [blg_pkg::MV_W-1:0] mv);
      gauge_sample_type s;
      s = '{now_us: t, sample_valid: ok, sample_mv: mv};
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.now_us       <= s.now_us;
      req_bus.sample_valid <= s.sample_valid;
      req_bus.sample_mv    <= s.sample_mv;
      do @(posedge clock); while (!req_bus.ready);
      predict_level(s);
      words_sent++;
   endtask

   // Stop sending and wait until every pending level has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (level_expected.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write a register over the APB port, then read it back.
   task automatic program_register(input blg_pkg::blg_reg_type idx,
                                   input logic [blg_pkg::DATA_W-1:0] value);
      logic [blg_pkg::DATA_W-1:0] stored;
      stored  = (idx == blg_pkg::REG_ENABLE) ?
                {{(blg_pkg::DATA_W-1){1'b0}}, value[0]} : value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= blg_pkg::ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == blg_pkg::REG_ENABLE) gauge_enable = value[0];
      else gauge_hold = value;

      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== stored)
         report_mismatch($sformatf("register %s reads 0x%h, wrote 0x%h",
                                   idx.name(), prdata, stored));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [blg_pkg::MV_W-1:0] random_mv();
      if ($urandom_range(0, 7) == 0) return blg_pkg::MV_W'($urandom_range(0, 4095));
      return blg_pkg::MV_W'($urandom_range(990, 1380));
   endfunction

   // Advance the stream clock: on, just short of, or around the hold interval.
   // One case steps by one, or in wide mode jumps by a share of the remaining range.
   function automatic logic [blg_pkg::TIME_W-1:0] next_stamp(
      input logic [blg_pkg::TIME_W-1:0] cur, input bit wide);
      logic [63:0] step;
      logic [63:0] room;
      logic [63:0] sum;
      room = {1'b0, TIME_CEILING - cur};
      case ($urandom_range(0, 7))
         0: step = {32'b0, gauge_hold};
         1: step = (gauge_hold == 0) ? 64'd0 : {32'b0, gauge_hold - 32'd1};
         2: step = wide ? {$urandom, $urandom} % (room / 8 + 64'd1) : 64'd1;
         default: step = {$urandom, $urandom} % ({31'b0, gauge_hold, 1'b0} + 64'd2);
      endcase
      sum = {1'b0, cur} + step;
      return (step > room) ? cur : sum[blg_pkg::TIME_W-1:0];
   endfunction

   // Mostly good readings on a rising clock, with late words from the past mixed in.
   task automatic run_stream(input int count, input bit wide);
      logic [blg_pkg::TIME_W-1:0] stamp;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 15) == 0 && stream_clock != 0) begin
            stamp = blg_pkg::TIME_W'({$urandom, $urandom}) % stream_clock;
         end else begin
            stream_clock = next_stamp(stream_clock, wide);
            stamp = stream_clock;
         end
         send_sample(stamp, $urandom_range(0, 7) != 0, random_mv());
      end
   endtask

   // While disabled every word returns -1 and the history stays untouched.
   task automatic check_disabled_block();
      send_sample('0, 1'b1, 12'd1374);
      send_sample(TIME_CEILING, 1'b0, 12'd4095);
      settle();
   endtask

   // First sample at time zero, hold window at its reset value, time going back.
   task automatic check_first_sample_and_hold();
      program_register(blg_pkg::REG_ENABLE, 32'd1);
      send_sample(63'd0, 1'b0, 12'd1300);
      send_sample(63'd100, 1'b1, 12'd1373);
      send_sample(63'd5000000, 1'b1, 12'd1374);
      send_sample(63'd10, 1'b1, 12'd0);
      send_sample(63'd9999999, 1'b1, 12'd0);
      send_sample(63'd10000000, 1'b1, 12'd1000);
      settle();
   endtask

   // A reading at or next to every point of the curve, the clamps and a failed read.
   task automatic check_charge_curve();
      program_register(blg_pkg::REG_HOLD, 32'd0);
      for (int i = 0; i < CURVE_POINTS; i++)
         send_sample(63'd20000000 + i, 1'b1, blg_pkg::MV_W'((CURVE_MV[i] + i % 2) / 3));
      send_sample(63'd20000100, 1'b1, 12'd4095);
      send_sample(63'd20000101, 1'b0, 12'd0);
      send_sample(63'd20000102, 1'b1, 12'd0);
      send_sample(63'd10, 1'b1, 12'd4095);
      settle();
   endtask

   // Random traffic under several hold settings, disabled and wide time ranges.
   task automatic check_random_traffic();
      stream_clock = 63'd30000000;
      run_stream(300, 1'b0);
      settle();
      program_register(blg_pkg::REG_HOLD, 32'($urandom_range(1, 5000)));
      run_stream(150, 1'b0);
      // The sender holds off here until the block has drained.
      settle();
      run_stream(150, 1'b0);
      settle();
      program_register(blg_pkg::REG_ENABLE, 32'd0);
      run_stream(60, 1'b0);
      settle();
      program_register(blg_pkg::REG_ENABLE, 32'd1);
      program_register(blg_pkg::REG_HOLD, 32'hFFFF_FFFF);
      run_stream(250, 1'b1);
      settle();
   endtask

   // Back to back traffic with no idling, ending at the top of the time range.
   task automatic check_quiet_tail();
      idle_on = 1'b0;
      program_register(blg_pkg::REG_HOLD, 32'($urandom_range(1, 3)));
      run_stream(188, 1'b0);
      settle();
      program_register(blg_pkg::REG_HOLD, 32'd0);
      send_sample(TIME_CEILING, 1'b1, 12'd1300);
      send_sample(TIME_CEILING, 1'b1, 12'd1001);
   endtask

   // The receiver stalls in random bursts while idling is on.
   initial begin
      rsp_bus.ready = 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each level word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         levels_checked++;
         if (level_expected.size() == 0) begin
            report_mismatch($sformatf("level %0d with nothing pending", rsp_bus.level_percent));
         end else begin
            level_wanted = level_expected.pop_front();
            if (rsp_bus.level_percent !== level_wanted)
               report_mismatch($sformatf("level %0d, expected %0d",
                                         rsp_bus.level_percent, level_wanted));
         end
      end
   end

   // End the run if no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles, %0d levels pending",
                  WATCHDOG_LIMIT, level_expected.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.now_us       = '0;
      req_bus.sample_valid = 1'b0;
      req_bus.sample_mv    = '0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      check_disabled_block();
      check_first_sample_and_hold();
      check_charge_curve();
      check_random_traffic();
      check_quiet_tail();

      settle();
      repeat (4) @(posedge clock);
      $display("Sent %0d words with the gauge on and off, hold windows from 0 to 2^32-1 us.",
               words_sent);
      $display("Checked %0d levels, %0d of them from a fresh curve lookup.",
               levels_checked, fresh_reads);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
